FILE: design/a85d_pkg.sv
// Shared types, character codes and helpers for the ASCII85 stream decoder.
// No dependencies; the front, queue, back and top-level files import it.
`default_nettype none

package a85d_pkg;

   localparam int A85D_QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_FIRST_DIGIT = 8'h21;  // '!'
   localparam logic [7:0] CH_LAST_DIGIT  = 8'h75;  // 'u'
   localparam logic [7:0] CH_ZERO_GROUP  = 8'h7A;  // 'z'
   localparam logic [7:0] CH_TILDE       = 8'h7E;  // '~'
   localparam logic [7:0] CH_GREATER     = 8'h3E;  // '>'
   localparam logic [7:0] CH_SPACE       = 8'h20;
   localparam logic [7:0] CH_TAB         = 8'h09;
   localparam logic [7:0] CH_CR          = 8'h0D;

   localparam logic [31:0] A85D_BASE = 32'd85;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_Z_IN_GROUP = 2'd1;
   localparam logic [1:0] ERR_SINGLE     = 2'd2;
   localparam logic [1:0] ERR_INVALID    = 2'd3;

   // One queue entry describes every result caused by one input word.
   typedef struct packed {
      logic [31:0] data;        // bytes, most significant first
      logic [1:0]  last_idx;    // number of results minus one
      logic        byte_valid;
      logic [1:0]  error_code;
      logic        stream_done;
   } entry_type;

   // Padding a group of n digits with 'u' (84) up to five digits equals
   // (acc + 1) * 85^(5-n) - 1, so only the power is needed.
   function automatic logic [19:0] pad_power(input logic [2:0] count);
      logic [19:0] p;
      case (count)
         3'd2:    p = 20'd614125;
         3'd3:    p = 20'd7225;
         3'd4:    p = 20'd85;
         default: p = 20'd1;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: design/a85d_if.sv
// Valid/ready channel interfaces for the ASCII85 decoder request and response words.
// No dependencies.
`default_nettype none

interface a85d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_buffer;

   modport source (output valid, in_char, end_of_buffer, input ready);
   modport sink   (input valid, in_char, end_of_buffer, output ready);
endinterface

interface a85d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       stream_done;
   logic [1:0] error_code;

   modport source (output valid, out_byte, byte_valid, run_last, stream_done, error_code,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, run_last, stream_done, error_code,
                   output ready);
endinterface

`default_nettype wire

FILE: design/a85d_front.sv
// Front end: accepts characters, keeps the base-85 accumulator and stream state,
// and queues a result descriptor per word that has results. Uses a85d_pkg, a85d_req_if.
`default_nettype none

module a85d_front (
   input  wire                  clock,
   input  wire                  reset,
   a85d_req_if.sink             req,
   output logic                 push_valid,
   output a85d_pkg::entry_type  push_entry,
   input  wire                  push_ready
);
   import a85d_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        tilde_ff, tilde_in;
   logic        halted_ff, halted_in;

   logic [7:0]  c;
   logic        accept;
   logic        is_digit;
   logic        is_white;
   logic [31:0] acc_next_digit;
   logic [31:0] padded;
   logic [2:0]  res_count;
   logic        done;
   entry_type   ent;

   assign c         = req.in_char;
   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   assign is_digit = (c >= CH_FIRST_DIGIT) && (c <= CH_LAST_DIGIT);
   assign is_white = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

   assign acc_next_digit = acc_ff * A85D_BASE + {24'd0, c - CH_FIRST_DIGIT};
   assign padded = (acc_ff + 32'd1) * {12'd0, pad_power(cnt_ff)} - 32'd1;

   always_comb begin
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      tilde_in  = tilde_ff;
      halted_in = halted_ff;
      ent       = '0;
      res_count = 3'd0;
      done      = 1'b0;

      if (!halted_ff) begin
         if (tilde_ff) begin
            tilde_in  = 1'b0;
            halted_in = 1'b1;
            if (c == CH_GREATER) begin
               done = 1'b1;
               if (cnt_ff == 3'd1) begin
                  ent.error_code = ERR_SINGLE;
                  res_count      = 3'd1;
               end else if (cnt_ff >= 3'd2) begin
                  ent.data       = padded;
                  ent.byte_valid = 1'b1;
                  res_count      = cnt_ff - 3'd1;
               end
               acc_in = '0;
               cnt_in = '0;
            end else begin
               ent.error_code = ERR_INVALID;
               res_count      = 3'd1;
            end
         end else if (is_digit) begin
            if (cnt_ff == 3'd4) begin
               ent.data       = acc_next_digit;
               ent.byte_valid = 1'b1;
               res_count      = 3'd4;
               acc_in         = '0;
               cnt_in         = '0;
            end else begin
               acc_in = acc_next_digit;
               cnt_in = cnt_ff + 3'd1;
            end
         end else if (c == CH_ZERO_GROUP) begin
            if (cnt_ff != 3'd0) begin
               ent.error_code = ERR_Z_IN_GROUP;
               res_count      = 3'd1;
               halted_in      = 1'b1;
            end else begin
               ent.byte_valid = 1'b1;
               res_count      = 3'd4;
            end
         end else if (c == CH_TILDE) begin
            if (req.end_of_buffer) begin
               ent.error_code = ERR_INVALID;
               res_count      = 3'd1;
               halted_in      = 1'b1;
            end else begin
               tilde_in = 1'b1;
            end
         end else if (!is_white) begin
            ent.error_code = ERR_INVALID;
            res_count      = 3'd1;
            halted_in      = 1'b1;
         end
      end

      // Buffer end returns everything to the reset state, halted included.
      if (req.end_of_buffer) begin
         done      = 1'b1;
         acc_in    = '0;
         cnt_in    = '0;
         tilde_in  = 1'b0;
         halted_in = 1'b0;
      end
      if (done && (res_count == 3'd0)) begin
         res_count = 3'd1;
      end
      ent.stream_done = done;
      ent.last_idx    = 2'(res_count - 3'd1);
   end

   assign push_valid = accept && (res_count != 3'd0);
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         cnt_ff    <= '0;
         tilde_ff  <= 1'b0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         tilde_ff  <= tilde_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/a85d_queue.sv
// Short FIFO of result descriptors between the front and back ends.
// Uses a85d_pkg for the entry type.
`default_nettype none

module a85d_queue #(
   parameter int DEPTH = a85d_pkg::A85D_QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push_valid,
   input  a85d_pkg::entry_type  push_entry,
   output logic                 push_ready,
   output logic                 head_valid,
   output a85d_pkg::entry_type  head_entry,
   input  wire                  pop
);
   import a85d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/a85d_back.sv
// Back end: walks the head descriptor one result word at a time onto the response
// channel. Uses a85d_pkg and a85d_rsp_if.
`default_nettype none

module a85d_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  head_valid,
   input  a85d_pkg::entry_type  head_entry,
   output logic                 pop,
   a85d_rsp_if.source           rsp
);
   import a85d_pkg::*;

   logic [1:0] idx_ff;
   logic       fire;
   logic       at_last;

   assign at_last = (idx_ff == head_entry.last_idx);
   assign fire    = head_valid && rsp.ready;
   assign pop     = fire && at_last;

   assign rsp.valid       = head_valid;
   assign rsp.byte_valid  = head_entry.byte_valid;
   assign rsp.run_last    = at_last;
   assign rsp.stream_done = head_entry.stream_done;
   assign rsp.error_code  = head_entry.error_code;

   always_comb begin
      case (idx_ff)
         2'd0:    rsp.out_byte = head_entry.data[31:24];
         2'd1:    rsp.out_byte = head_entry.data[23:16];
         2'd2:    rsp.out_byte = head_entry.data[15:8];
         default: rsp.out_byte = head_entry.data[7:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (fire) begin
         idx_ff <= at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

endmodule

`default_nettype wire

FILE: design/ascii85_stream_decoder_core.sv
// ASCII85 stream decoder top level: front end, descriptor queue and back end.
// A word's descriptor is registered in the queue before the back end sends it.
// Throughput: one word per cycle while the queue has room; a word that yields k
// results sends k bytes over the one-byte response port (a full group sends four).
// Reset: synchronous, clears the accumulator, stream flags, queue and output index.
`default_nettype none

module ascii85_stream_decoder_core #(
   parameter int QUEUE_DEPTH = a85d_pkg::A85D_QUEUE_DEPTH
) (
   input  wire          clock,
   input  wire          reset,
   a85d_req_if.sink     req_ch,
   a85d_rsp_if.source   rsp_ch
);
   import a85d_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      head_valid, pop;
   entry_type head_entry;

   a85d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   a85d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   a85d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: design/a85d_checker.sv
// Port-level checks for ascii85_stream_decoder_core, attached with a bind.
// Depends on the top level's channel interfaces.
`default_nettype none

module a85d_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_out_byte,
   input wire       rsp_byte_valid,
   input wire       rsp_run_last,
   input wire       rsp_stream_done,
   input wire [1:0] rsp_error_code
);
   logic rsp_fire;
   assign rsp_fire = rsp_valid && rsp_ready;

   // A stalled response word keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_byte_valid) && $stable(rsp_error_code) && $stable(rsp_run_last))
      else $error("stalled response changed");

   // Error and empty results always stand alone.
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_byte_valid |-> rsp_run_last)
      else $error("non-data result is not the last of its word");

   // An error never comes with data.
   a_err_nodata: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && (rsp_error_code != 2'd0) |-> !rsp_byte_valid && (rsp_out_byte == 8'd0))
      else $error("error result carries data");

   // A result without data or error only reports the end of the stream.
   a_empty_done: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_byte_valid && (rsp_error_code == 2'd0) |-> rsp_stream_done)
      else $error("empty result outside stream end");

   // Nothing is pending right after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ascii85_stream_decoder_core a85d_checker u_a85d_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_byte_valid  (rsp_ch.byte_valid),
   .rsp_run_last    (rsp_ch.run_last),
   .rsp_stream_done (rsp_ch.stream_done),
   .rsp_error_code  (rsp_ch.error_code)
);

`default_nettype wire

FILE: tb/ascii85_stream_decoder_core_tb.sv
// Self-checking testbench for ascii85_stream_decoder_core: a directed table, then random streams.
// Depends on a85d_pkg and the a85d_req_if / a85d_rsp_if channel interfaces.

module ascii85_stream_decoder_core_tb;
   import a85d_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       stream_done;
      logic [1:0] error_code;
   } byte_word_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          eob;
      logic          typed;      // exp below holds the single expected byte word
      byte_word_type exp;
   } char_row_type;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 240;
   localparam int N_DIRECTED  = 32;

   localparam byte_word_type NO_CHECK  = '0;
   localparam byte_word_type ERR3_MID  = '{8'h00, 1'b0, 1'b1, 1'b0, ERR_INVALID};
   localparam byte_word_type ERR3_END  = '{8'h00, 1'b0, 1'b1, 1'b1, ERR_INVALID};
   localparam byte_word_type ERR1_MID  = '{8'h00, 1'b0, 1'b1, 1'b0, ERR_Z_IN_GROUP};
   localparam byte_word_type ERR2_END  = '{8'h00, 1'b0, 1'b1, 1'b1, ERR_SINGLE};
   localparam byte_word_type BARE_DONE = '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE};

   localparam char_row_type DIRECTED_ROWS [0:N_DIRECTED-1] = '{
      '{8'h00, 1'b0, 1'b1, ERR3_MID},        // invalid control character
      '{"A",   1'b1, 1'b1, BARE_DONE},       // halted, buffer end releases
      '{"s",   1'b0, 1'b0, NO_CHECK},        // "s8W-!" decodes to all ones
      '{"8",   1'b0, 1'b0, NO_CHECK},
      '{"W",   1'b0, 1'b0, NO_CHECK},
      '{"-",   1'b0, 1'b0, NO_CHECK},
      '{"!",   1'b0, 1'b0, NO_CHECK},
      '{CH_TAB, 1'b0, 1'b0, NO_CHECK},
      '{CH_LAST_DIGIT, 1'b0, 1'b0, NO_CHECK}, // five 'u' digits wrap the accumulator
      '{CH_LAST_DIGIT, 1'b0, 1'b0, NO_CHECK},
      '{CH_LAST_DIGIT, 1'b0, 1'b0, NO_CHECK},
      '{CH_LAST_DIGIT, 1'b0, 1'b0, NO_CHECK},
      '{CH_LAST_DIGIT, 1'b0, 1'b0, NO_CHECK},
      '{CH_ZERO_GROUP, 1'b0, 1'b0, NO_CHECK},
      '{CH_FIRST_DIGIT, 1'b0, 1'b0, NO_CHECK},
      '{CH_ZERO_GROUP, 1'b0, 1'b1, ERR1_MID},
      '{CH_SPACE, 1'b1, 1'b1, BARE_DONE},
      '{CH_TILDE, 1'b1, 1'b1, ERR3_END},     // tilde on the last character of the buffer
      '{"5",   1'b0, 1'b0, NO_CHECK},
      '{CH_TILDE, 1'b0, 1'b0, NO_CHECK},
      '{CH_GREATER, 1'b0, 1'b1, ERR2_END},   // one-digit final group
      '{8'hFF, 1'b1, 1'b1, BARE_DONE},
      '{CH_TILDE, 1'b0, 1'b0, NO_CHECK},
      '{CH_GREATER, 1'b1, 1'b1, BARE_DONE},  // end marker with nothing to flush
      '{"G",   1'b0, 1'b0, NO_CHECK},
      '{"a",   1'b0, 1'b0, NO_CHECK},
      '{"9",   1'b0, 1'b0, NO_CHECK},
      '{CH_TILDE, 1'b0, 1'b0, NO_CHECK},
      '{CH_GREATER, 1'b1, 1'b0, NO_CHECK},
      '{CH_TILDE, 1'b0, 1'b0, NO_CHECK},
      '{"x",   1'b0, 1'b1, ERR3_MID},        // tilde not followed by '>'
      '{8'h0C, 1'b1, 1'b1, BARE_DONE}
   };

   logic clock;
   logic reset;

   a85d_req_if req_bus();
   a85d_rsp_if rsp_bus();

   ascii85_stream_decoder_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   char_row_type  char_stream[$];
   byte_word_type expected_bytes[$];
   byte_word_type step_out[$];
   int            next_word;
   int            errors;
   int            hold_left;
   bit            hold_used;

   // Decoder state as the predictor sees it.
   logic [31:0] dec_acc;
   logic [2:0]  dec_count;
   logic        dec_tilde;
   logic        dec_halted;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void add_result(input logic [7:0] b, input logic v, input logic [1:0] e);
      step_out.push_back('{b, v, 1'b0, 1'b0, e});
   endfunction

   // Work out the byte words caused by one character word and advance the state.
   function automatic void decode_char(input logic [7:0] c, input logic eob);
      logic        done;
      logic [31:0] v;
      int          k;
      done = 1'b0;
      step_out.delete();
      if (!dec_halted) begin
         if (dec_tilde) begin
            dec_tilde  = 1'b0;
            dec_halted = 1'b1;
            if (c == CH_GREATER) begin
               done = 1'b1;
               if (dec_count == 3'd1) begin
                  add_result(8'h00, 1'b0, ERR_SINGLE);
               end else if (dec_count >= 3'd2) begin
                  // Pad the partial group with the highest digit, keep count-1 bytes.
                  v = dec_acc;
                  for (k = dec_count; k < 5; k++) v = v * A85D_BASE + 32'd84;
                  for (k = 0; k + 1 < dec_count; k++)
                     add_result(v[31 - 8*k -: 8], 1'b1, ERR_NONE);
               end
               dec_acc   = '0;
               dec_count = '0;
            end else begin
               add_result(8'h00, 1'b0, ERR_INVALID);
            end
         end else if (c >= CH_FIRST_DIGIT && c <= CH_LAST_DIGIT) begin
            dec_acc   = dec_acc * A85D_BASE + (c - CH_FIRST_DIGIT);
            dec_count = dec_count + 3'd1;
            if (dec_count >= 3'd5) begin
               for (k = 0; k < 4; k++) add_result(dec_acc[31 - 8*k -: 8], 1'b1, ERR_NONE);
               dec_acc   = '0;
               dec_count = '0;
            end
         end else if (c == CH_ZERO_GROUP) begin
            if (dec_count != 3'd0) begin
               add_result(8'h00, 1'b0, ERR_Z_IN_GROUP);
               dec_halted = 1'b1;
            end else begin
               for (k = 0; k < 4; k++) add_result(8'h00, 1'b1, ERR_NONE);
            end
         end else if (c == CH_TILDE) begin
            if (eob) begin
               add_result(8'h00, 1'b0, ERR_INVALID);
               dec_halted = 1'b1;
            end else begin
               dec_tilde = 1'b1;
            end
         end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            add_result(8'h00, 1'b0, ERR_INVALID);
            dec_halted = 1'b1;
         end
      end
      if (eob) begin
         done       = 1'b1;
         dec_acc    = '0;
         dec_count  = '0;
         dec_tilde  = 1'b0;
         dec_halted = 1'b0;
      end
      if (done && step_out.size() == 0) add_result(8'h00, 1'b0, ERR_NONE);
      if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
      if (done) foreach (step_out[i]) step_out[i].stream_done = 1'b1;
   endfunction

   function automatic void push_char(input logic [7:0] c, input logic eob);
      char_stream.push_back('{c, eob, 1'b0, NO_CHECK});
   endfunction

   function automatic logic [7:0] digit_char();
      return CH_FIRST_DIGIT + 8'($urandom_range(0, 84));
   endfunction

   function automatic logic [7:0] white_char();
      int pick;
      pick = $urandom_range(0, 5);
      return (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
   endfunction

   // One random stream, mostly well formed, always closed by a buffer end.
   function automatic void add_stream();
      int groups;
      int tail;
      int ending;
      int g;
      int d;
      groups = $urandom_range(0, 4);
      for (g = 0; g < groups; g++) begin
         if ($urandom_range(0, 9) < 2) begin
            push_char(CH_ZERO_GROUP, 1'b0);
         end else begin
            for (d = 0; d < 5; d++) begin
               if ($urandom_range(0, 9) == 0) push_char(white_char(), 1'b0);
               push_char(digit_char(), 1'b0);
            end
         end
      end
      tail   = $urandom_range(0, 4);
      for (d = 0; d < tail; d++) push_char(digit_char(), 1'b0);
      ending = $urandom_range(0, 9);
      if (ending <= 6) begin
         push_char(CH_TILDE, 1'b0);
         if (ending <= 2) begin
            push_char(CH_GREATER, 1'b1);
         end else begin
            push_char(CH_GREATER, 1'b0);
            push_char(8'($urandom_range(0, 255)), 1'b1);
         end
      end else if (ending == 7) begin
         // Buffer end without the marker drops the partial group.
         push_char(digit_char(), 1'b1);
      end else if (ending == 8) begin
         push_char(CH_TILDE, 1'b0);
         push_char(8'($urandom_range(0, 255)), 1'b0);
         push_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         for (d = $urandom_range(1, 3); d > 0; d--) push_char(8'($urandom_range(0, 255)), 1'b0);
         push_char(8'($urandom_range(0, 255)), 1'b1);
      end
   endfunction

   // Idle percentages by thirds of the run: the sender rarely and the receiver often,
   // then the other way round, then neither.
   function automatic int idle_pct(input bit receiver);
      int third;
      third = (next_word * 3) / char_stream.size();
      if (third == 0) return receiver ? 66 : 6;
      if (third == 1) return receiver ? 6 : 66;
      return 0;
   endfunction

   // Sender: holds a word until it is taken, then offers the next one or idles.
   always @(posedge clock) begin : sender
      logic taken;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         taken = req_bus.valid && req_bus.ready;
         if (taken) begin
            decode_char(char_stream[next_word].ch, char_stream[next_word].eob);
            if (char_stream[next_word].typed) begin
               expected_bytes.push_back(char_stream[next_word].exp);
            end else begin
               foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
            end
            next_word++;
         end
         if (taken || !req_bus.valid) begin
            if (next_word < char_stream.size() && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
               req_bus.valid         <= 1'b1;
               req_bus.in_char       <= char_stream[next_word].ch;
               req_bus.end_of_buffer <= char_stream[next_word].eob;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold late in the run so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_used && next_word >= (char_stream.size() * 5) / 6) begin
         hold_left     <= HOLD_CYCLES;
         hold_used     <= 1'b1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
   end

   always @(posedge clock) begin : response_check
      byte_word_type got;
      byte_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_byte, rsp_bus.byte_valid, rsp_bus.run_last,
                 rsp_bus.stream_done, rsp_bus.error_code};
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte word byte=%h valid=%b last=%b done=%b err=%0d",
                     $time, got.out_byte, got.byte_valid, got.run_last, got.stream_done,
                     got.error_code);
            errors++;
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want) begin
               $display("%0t: expected byte=%h valid=%b last=%b done=%b err=%0d", $time,
                        want.out_byte, want.byte_valid, want.run_last, want.stream_done,
                        want.error_code);
               $display("%0t: actual   byte=%h valid=%b last=%b done=%b err=%0d", $time,
                        got.out_byte, got.byte_valid, got.run_last, got.stream_done,
                        got.error_code);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
         else quiet++;
      end
      $display("ascii85_stream_decoder_core verification failed");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.in_char       = 8'h00;
      req_bus.end_of_buffer = 1'b0;
      rsp_bus.ready         = 1'b0;
      next_word  = 0;
      errors     = 0;
      hold_left  = 0;
      hold_used  = 1'b0;
      dec_acc    = '0;
      dec_count  = '0;
      dec_tilde  = 1'b0;
      dec_halted = 1'b0;
      foreach (DIRECTED_ROWS[i]) char_stream.push_back(DIRECTED_ROWS[i]);
      while (char_stream.size() < N_DIRECTED + 200) add_stream();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (next_word < char_stream.size() || expected_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("ascii85_stream_decoder_core verification clean");
      end else begin
         $display("ascii85_stream_decoder_core verification failed");
      end
      $finish;
   end

endmodule
